/* sv/ncc_pkg.sv */
`default_nettype none
package ncc_pkg;

  localparam int unsigned MAX_WIDTH_DEF     = 1024;
  localparam int unsigned WINDOW_RADIUS_DEF = 4;
  localparam int unsigned MAX_DISP_SPAN_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // quotient bits of the score below the saturation point
  localparam int unsigned SCORE_FRAC_W = 15;

  localparam logic [10:0]        IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [10:0]        IMAGE_HEIGHT_RST = 11'd1024;
  localparam logic signed [15:0] THRESHOLD_RST    = -16'sd32768;
  localparam logic signed [6:0]  DISP_MIN_RST     = -7'sd30;
  localparam logic signed [6:0]  DISP_MAX_RST     = -7'sd7;

  localparam logic signed [15:0] SCORE_MIN = -16'sd32768;
  localparam logic signed [15:0] SCORE_MAX = 16'sd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_NCC_THRESHOLD = 3'd2,
    REG_DISPARITY_MIN = 3'd3,
    REG_DISPARITY_MAX = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
    logic       frame_start;
  } ncc_in_t;

  typedef struct packed {
    logic [9:0]        pixel_x;
    logic [9:0]        pixel_y;
    logic signed [7:0] disparity;
    logic              is_seed;
    logic signed [15:0] best_score;
  } ncc_out_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rd_ctrl_t;

endpackage
`default_nettype wire

/* sv/ncc_stereo_disparity_search.sv */
// Per pixel: position alignment steps, then per tried disparity N = (2R+1)^2
// window reads on the line buffer ports, a root of width W (29 at R = 4) on the
// shared root/divide unit and, unless the score saturates, a divide on it. An
// out-of-row disparity skips the window reads. A new pixel is taken only when idle.
// Reset (async, active low) clears counters, configuration and the sequencer;
// line buffer contents are undefined until written.
`default_nettype none
module ncc_stereo_disparity_search #(
  parameter int unsigned MAX_WIDTH          = ncc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WINDOW_RADIUS      = ncc_pkg::WINDOW_RADIUS_DEF,
  parameter int unsigned MAX_DISPARITY_SPAN = ncc_pkg::MAX_DISP_SPAN_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire ncc_pkg::ncc_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output ncc_pkg::ncc_out_t                     out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ncc_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [ncc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned RR     = 2 * WINDOW_RADIUS + 2;
  localparam int unsigned SLW    = $clog2(RR);
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned AW     = SLW + CW;
  localparam int unsigned DEPTH  = RR * (2 ** CW);
  localparam int unsigned WIN    = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned N      = WIN * WIN;
  localparam int unsigned IW     = $clog2(WIN);
  localparam int unsigned S_W    = $clog2(N * 255 + 1);
  localparam int unsigned SQ_W   = $clog2(N * 65025 + 1);
  localparam int unsigned V_W    = $clog2(N * N * 65025 + 1);
  localparam int unsigned DEN_W  = V_W + 4;
  localparam int unsigned UNIT_W = V_W + 21;
  localparam int unsigned WLIM   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  localparam logic [IW-1:0]      I_LAST = IW'(WIN - 1);
  localparam logic signed [13:0] RAD    = 14'(WINDOW_RADIUS);
  localparam logic [SLW-1:0]     SL_LAST = SLW'(RR - 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_ALIGN = 12'b0000_0000_0010,
    ST_CHECK = 12'b0000_0000_0100,
    ST_DISP  = 12'b0000_0000_1000,
    ST_ACC   = 12'b0000_0001_0000,
    ST_DRAIN = 12'b0000_0010_0000,
    ST_MATH  = 12'b0000_0100_0000,
    ST_ROOT  = 12'b0000_1000_0000,
    ST_DEN   = 12'b0001_0000_0000,
    ST_DIV   = 12'b0010_0000_0000,
    ST_SCORE = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } state_e;

  state_e state_q;

  // configuration
  logic [10:0]        img_w_q, img_h_q;
  logic signed [15:0] thr_q;
  logic signed [6:0]  dmin_q, dmax_q;

  // raster position
  logic [9:0]     col_q, row_q;
  logic [SLW-1:0] slot_q;

  // target and search
  logic signed [13:0] x_q, y_q;
  logic [SLW-1:0]     yslot_q, rslot_q;
  logic signed [7:0]  d_q, best_d_q;
  logic signed [15:0] best_q;
  logic               seed_q;
  logic [IW-1:0]      i_q, j_q;
  logic signed [13:0] lcol_q, rcol_q;
  logic               rdv_q;
  logic [S_W-1:0]     s1_q, s2_q;
  logic [SQ_W-1:0]    s11_q, s22_q, s12_q;
  logic [2:0]         mk_q;
  logic [2*V_W-1:0]   m_q;
  logic [V_W-1:0]     t_q, v1_q, v2_q, c_mag_q;
  logic               c_neg_q, sat_q;

  logic               out_valid_q;
  ncc_pkg::ncc_out_t  out_q;

  // derived values
  logic [10:0]        w_eff, h_eff;
  logic signed [9:0]  dmn, dmx, dlim, dmax_eff;
  logic signed [13:0] lag;
  logic               accept;
  logic [9:0]         cx, cy;
  logic [SLW-1:0]     cslot;
  logic [12:0]        cx13;
  logic signed [13:0] xd, x_lo, xd_lo;
  logic               win_ok, emit_ok, last_d, emit_go;
  logic [7:0]         l_rd, r_rd;
  logic [15:0]        aa, bb, ab;
  logic [V_W-1:0]     mul_a, mul_b;
  logic [2*V_W:0]     cdiff;
  logic [V_W-1:0]     rt;
  logic [DEN_W-1:0]   den;
  logic [UNIT_W-1:0]  num, dvs;
  logic               sat_d;
  logic signed [15:0] score;
  ncc_pkg::rd_ctrl_t  rd_ctrl;
  logic               rd_busy, rd_done;

  always_comb begin
    w_eff = img_w_q;
    if (w_eff == 11'd0) w_eff = 11'd1;
    if (w_eff > 11'(WLIM)) w_eff = 11'(WLIM);
    h_eff = img_h_q;
    if (h_eff == 11'd0) h_eff = 11'd1;
    if (h_eff > 11'd1024) h_eff = 11'd1024;
  end

  assign dmn      = 10'(dmin_q);
  assign dmx      = 10'(dmax_q);
  assign dlim     = dmn + 10'(MAX_DISPARITY_SPAN - 1);
  assign dmax_eff = (dmx > dlim) ? dlim : dmx;
  assign lag      = RAD + ((dmax_eff > 10'sd0) ? 14'(dmax_eff) : 14'sd0);

  assign accept = in_valid_i && in_ready_o;
  assign cx     = in_data_i.frame_start ? 10'd0 : col_q;
  assign cy     = in_data_i.frame_start ? 10'd0 : row_q;
  assign cslot  = in_data_i.frame_start ? '0 : slot_q;
  assign cx13   = 13'(cx);

  assign xd     = x_q + 14'(d_q);
  assign x_lo   = x_q - RAD;
  assign xd_lo  = xd - RAD;
  assign win_ok = (xd + RAD < $signed({3'b0, w_eff})) && (xd_lo >= 14'sd0);
  assign emit_ok = (y_q >= RAD) && (x_q >= RAD) &&
                   (x_q + RAD < $signed({3'b0, w_eff})) &&
                   (y_q + RAD < $signed({3'b0, h_eff}));
  assign last_d  = (d_q == 8'(dmax_eff));
  assign emit_go = !out_valid_q || out_ready_i;

  ncc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_left_rows (
    .clk_i   (clk_i),
    .we_i    (accept && (cx13 < 13'(MAX_WIDTH))),
    .waddr_i ({cslot, cx13[CW-1:0]}),
    .wdata_i (in_data_i.left_pixel),
    .raddr_i ({rslot_q, lcol_q[CW-1:0]}),
    .rdata_o (l_rd)
  );

  ncc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_right_rows (
    .clk_i   (clk_i),
    .we_i    (accept && (cx13 < 13'(MAX_WIDTH))),
    .waddr_i ({cslot, cx13[CW-1:0]}),
    .wdata_i (in_data_i.right_pixel),
    .raddr_i ({rslot_q, rcol_q[CW-1:0]}),
    .rdata_o (r_rd)
  );

  assign aa = 16'(l_rd) * 16'(l_rd);
  assign bb = 16'(r_rd) * 16'(r_rd);
  assign ab = 16'(l_rd) * 16'(r_rd);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mk_q)
      3'd0: begin mul_a = V_W'(N);    mul_b = V_W'(s11_q); end
      3'd1: begin mul_a = V_W'(s1_q); mul_b = V_W'(s1_q);  end
      3'd2: begin mul_a = V_W'(N);    mul_b = V_W'(s22_q); end
      3'd3: begin mul_a = V_W'(s2_q); mul_b = V_W'(s2_q);  end
      3'd4: begin mul_a = V_W'(N);    mul_b = V_W'(s12_q); end
      3'd5: begin mul_a = V_W'(s1_q); mul_b = V_W'(s2_q);  end
      3'd6: begin mul_a = v1_q;       mul_b = v2_q;        end
      default: begin mul_a = '0;      mul_b = '0;          end
    endcase
  end

  assign cdiff = {1'b0, V_W'(0), t_q} - {1'b0, m_q};

  // score = round(C * 327680 / (10 * root + N)), numerator and divisor doubled
  assign rt    = rd_busy ? '0 : V_W'(0) | ncc_res;
  logic [V_W-1:0] ncc_res;
  assign den   = (DEN_W'(rt) << 3) + (DEN_W'(rt) << 1) + DEN_W'(N);
  assign num   = (UNIT_W'(c_mag_q) << 19) + (UNIT_W'(c_mag_q) << 17) + UNIT_W'(den);
  assign dvs   = UNIT_W'(den) << ncc_pkg::SCORE_FRAC_W;
  assign sat_d = num >= (UNIT_W'(den) << (ncc_pkg::SCORE_FRAC_W + 1));

  always_comb begin
    if (sat_q) begin
      score = c_neg_q ? ncc_pkg::SCORE_MIN : ncc_pkg::SCORE_MAX;
    end else if (c_neg_q) begin
      score = -$signed({1'b0, ncc_res[ncc_pkg::SCORE_FRAC_W-1:0]});
    end else begin
      score = $signed({1'b0, ncc_res[ncc_pkg::SCORE_FRAC_W-1:0]});
    end
  end

  always_comb begin
    rd_ctrl.start  = ((state_q == ST_MATH) && (mk_q == 3'd7)) ||
                     ((state_q == ST_DEN) && !sat_d);
    rd_ctrl.is_div = (state_q == ST_DEN);
  end

  ncc_root_div #(.ROOT_W(V_W), .UNIT_W(UNIT_W)) u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rd_ctrl),
    .rad_i  (m_q),
    .num_i  (num),
    .dvs_i  (dvs),
    .busy_o (rd_busy),
    .done_o (rd_done),
    .res_o  (ncc_res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      img_w_q     <= ncc_pkg::IMAGE_WIDTH_RST;
      img_h_q     <= ncc_pkg::IMAGE_HEIGHT_RST;
      thr_q       <= ncc_pkg::THRESHOLD_RST;
      dmin_q      <= ncc_pkg::DISP_MIN_RST;
      dmax_q      <= ncc_pkg::DISP_MAX_RST;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      mk_q        <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (ncc_pkg::cfg_reg_e'(cfg_addr_i))
          ncc_pkg::REG_IMAGE_WIDTH:   img_w_q <= cfg_wdata_i[10:0];
          ncc_pkg::REG_IMAGE_HEIGHT:  img_h_q <= cfg_wdata_i[10:0];
          ncc_pkg::REG_NCC_THRESHOLD: thr_q   <= $signed(cfg_wdata_i[15:0]);
          ncc_pkg::REG_DISPARITY_MIN: dmin_q  <= $signed(cfg_wdata_i[6:0]);
          ncc_pkg::REG_DISPARITY_MAX: dmax_q  <= $signed(cfg_wdata_i[6:0]);
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      rdv_q <= (state_q == ST_ACC);

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (11'(cx) + 11'd1 >= w_eff) begin
              col_q <= '0;
              if (11'(cy) + 11'd1 >= h_eff) begin
                row_q  <= '0;
                slot_q <= '0;
              end else begin
                row_q  <= cy + 10'd1;
                slot_q <= (cslot == SL_LAST) ? '0 : cslot + 1'b1;
              end
            end else begin
              col_q  <= cx + 10'd1;
              row_q  <= cy;
              slot_q <= cslot;
            end
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (!x_q[13] && (x_q < $signed({3'b0, w_eff}))) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!emit_ok) state_q <= ST_IDLE;
          else if (dmn > dmax_eff) state_q <= ST_EMIT;
          else state_q <= ST_DISP;
        end
        ST_DISP: begin
          i_q <= '0;
          j_q <= '0;
          if (win_ok) state_q <= ST_ACC;
          else if (last_d) state_q <= ST_EMIT;
        end
        ST_ACC: begin
          if (i_q == I_LAST) begin
            i_q <= '0;
            j_q <= j_q + 1'b1;
            if (j_q == I_LAST) state_q <= ST_DRAIN;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          mk_q    <= '0;
          state_q <= ST_MATH;
        end
        ST_MATH: begin
          mk_q <= mk_q + 1'b1;
          if (mk_q == 3'd7) state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rd_done) state_q <= ST_DEN;
        end
        ST_DEN: begin
          state_q <= sat_d ? ST_SCORE : ST_DIV;
        end
        ST_DIV: begin
          if (rd_done) state_q <= ST_SCORE;
        end
        ST_SCORE: begin
          state_q <= last_d ? ST_EMIT : ST_DISP;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      s1_q  <= s1_q + S_W'(l_rd);
      s2_q  <= s2_q + S_W'(r_rd);
      s11_q <= s11_q + SQ_W'(aa);
      s22_q <= s22_q + SQ_W'(bb);
      s12_q <= s12_q + SQ_W'(ab);
    end

    case (state_q)
      ST_IDLE: begin
        x_q     <= $signed({4'b0, cx}) - lag;
        y_q     <= $signed({4'b0, cy}) - RAD;
        yslot_q <= (cslot >= SLW'(WINDOW_RADIUS)) ? cslot - SLW'(WINDOW_RADIUS) :
                   cslot + SLW'(RR - WINDOW_RADIUS);
      end
      ST_ALIGN: begin
        // bring the column into [0, width), moving rows as needed
        if (x_q[13]) begin
          x_q     <= x_q + $signed({3'b0, w_eff});
          y_q     <= y_q - 14'sd1;
          yslot_q <= (yslot_q == '0) ? SL_LAST : yslot_q - 1'b1;
        end else if (x_q >= $signed({3'b0, w_eff})) begin
          x_q     <= x_q - $signed({3'b0, w_eff});
          y_q     <= y_q + 14'sd1;
          yslot_q <= (yslot_q == SL_LAST) ? '0 : yslot_q + 1'b1;
        end
      end
      ST_CHECK: begin
        d_q      <= 8'(dmin_q);
        best_d_q <= 8'(dmin_q) - 8'sd1;
        best_q   <= ncc_pkg::SCORE_MIN;
        seed_q   <= 1'b0;
      end
      ST_DISP: begin
        s1_q    <= '0;
        s2_q    <= '0;
        s11_q   <= '0;
        s22_q   <= '0;
        s12_q   <= '0;
        lcol_q  <= x_lo;
        rcol_q  <= xd_lo;
        rslot_q <= (yslot_q >= SLW'(WINDOW_RADIUS)) ? yslot_q - SLW'(WINDOW_RADIUS) :
                   yslot_q + SLW'(RR - WINDOW_RADIUS);
        if (!win_ok && !last_d) d_q <= d_q + 8'sd1;
      end
      ST_ACC: begin
        if (i_q == I_LAST) begin
          lcol_q  <= x_lo;
          rcol_q  <= xd_lo;
          rslot_q <= (rslot_q == SL_LAST) ? '0 : rslot_q + 1'b1;
        end else begin
          lcol_q <= lcol_q + 14'sd1;
          rcol_q <= rcol_q + 14'sd1;
        end
      end
      ST_MATH: begin
        m_q <= (2*V_W)'(mul_a) * (2*V_W)'(mul_b);
        case (mk_q)
          3'd1, 3'd3, 3'd5: t_q <= m_q[V_W-1:0];
          3'd2: v1_q <= t_q - m_q[V_W-1:0];
          3'd4: v2_q <= t_q - m_q[V_W-1:0];
          3'd6: begin
            c_neg_q <= cdiff[2*V_W];
            c_mag_q <= cdiff[2*V_W] ? V_W'(m_q[V_W-1:0] - t_q) : V_W'(cdiff);
          end
          default: ;
        endcase
      end
      ST_DEN: begin
        sat_q <= sat_d;
      end
      ST_SCORE: begin
        if ((score >= thr_q) && (score >= best_q)) begin
          best_q   <= score;
          best_d_q <= d_q;
          seed_q   <= 1'b1;
        end
        if (!last_d) d_q <= d_q + 8'sd1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_q.pixel_x    <= x_q[9:0];
          out_q.pixel_y    <= y_q[9:0];
          out_q.disparity  <= best_d_q;
          out_q.is_seed    <= seed_q;
          out_q.best_score <= best_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ctrl.start |-> !rd_busy)
    else $error("root/divide unit started while busy");

  a_done_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ctrl.start |=> !rd_done)
    else $error("root/divide result one cycle after start");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && out_valid_q && !out_ready_i |=> $stable(out_data_o))
    else $error("pending result overwritten");

  a_win_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> !lcol_q[13] && (lcol_q < $signed({3'b0, w_eff})))
    else $error("window read outside the row");

endmodule
`default_nettype wire

/* sv/ncc_ram.sv */
`default_nettype none
module ncc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/ncc_root_div.sv */
`default_nettype none
// Shared compare-subtract unit: integer square root, one result bit per cycle,
// or restoring division, one quotient bit per cycle.
module ncc_root_div #(
  parameter int unsigned ROOT_W = 29,
  parameter int unsigned UNIT_W = 50
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ncc_pkg::rd_ctrl_t     ctrl_i,
  input  wire logic [2*ROOT_W-1:0]   rad_i,
  input  wire logic [UNIT_W-1:0]     num_i,
  input  wire logic [UNIT_W-1:0]     dvs_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [ROOT_W-1:0]          res_o
);

  localparam int unsigned MAX_IT = (ROOT_W > ncc_pkg::SCORE_FRAC_W) ?
                                   ROOT_W : ncc_pkg::SCORE_FRAC_W;
  localparam int unsigned CNT_W  = $clog2(MAX_IT + 1);

  logic              busy_q, done_q, div_mode_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [UNIT_W-1:0] rem_q, dv_q;
  logic [ROOT_W-1:0] acc_q;

  logic [UNIT_W-1:0] r2, trial, op_a, op_b;
  logic [UNIT_W:0]   diff;
  logic              ge;

  assign r2    = {rem_q[UNIT_W-3:0], rad_q[2*ROOT_W-1 -: 2]};
  assign trial = UNIT_W'({acc_q, 2'b01});
  assign op_a  = div_mode_q ? rem_q : r2;
  assign op_b  = div_mode_q ? dv_q : trial;
  assign diff  = {1'b0, op_a} - {1'b0, op_b};
  assign ge    = !diff[UNIT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      div_mode_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start && !busy_q) begin
        busy_q     <= 1'b1;
        div_mode_q <= ctrl_i.is_div;
        cnt_q      <= ctrl_i.is_div ? CNT_W'(ncc_pkg::SCORE_FRAC_W) : CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      rad_q <= rad_i;
      rem_q <= ctrl_i.is_div ? num_i : '0;
      dv_q  <= dvs_i;
      acc_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[UNIT_W-1:0] : op_a;
      acc_q <= {acc_q[ROOT_W-2:0], ge};
      rad_q <= rad_q << 2;
      dv_q  <= dv_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule
`default_nettype wire

/* tb/ncc_stereo_disparity_search_tb.sv */
`timescale 1ns / 1ps
module ncc_stereo_disparity_search_tb;
  import ncc_pkg::*;

  localparam int RAD   = 4;
  localparam int SPAN  = 32;
  localparam int RING  = 2 * RAD + 2;
  localparam int MAXW  = 1024;
  localparam int NWIN  = (2 * RAD + 1) * (2 * RAD + 1);
  localparam int DRAIN = 6000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  ncc_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  ncc_out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ncc_stereo_disparity_search DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // line buffers and position, mirrored from the block
  logic [7:0] left_ring[RING*MAXW];
  logic [7:0] right_ring[RING*MAXW];
  int col_pos, row_pos;
  logic [10:0] width_reg, height_reg;
  logic signed [15:0] thresh_reg;
  logic signed [6:0] dmin_reg, dmax_reg;

  ncc_out_t pending_matches[$];
  int mismatches, pixels_sent, matches_seen, seeds_seen, fallbacks_seen;
  int tx_idle_pct, rx_idle_pct;

  typedef struct {
    logic [7:0] left;
    logic [7:0] right;
    logic       fs;
    bit         has_match;
  } directed_row_t;

  // sizes saturate to one pixel, so none of these rows may produce a match
  directed_row_t directed_rows[] = '{
    '{8'h00, 8'h00, 1'b1, 1'b0}, '{8'hFF, 8'hFF, 1'b0, 1'b0},
    '{8'h00, 8'hFF, 1'b0, 1'b0}, '{8'hFF, 8'h00, 1'b1, 1'b0},
    '{8'h55, 8'hAA, 1'b0, 1'b0}, '{8'hAA, 8'h55, 1'b0, 1'b0},
    '{8'h01, 8'h80, 1'b1, 1'b0}, '{8'h80, 8'h01, 1'b0, 1'b0},
    '{8'h7F, 8'hFE, 1'b0, 1'b0}, '{8'hFE, 8'h7F, 1'b1, 1'b0},
    '{8'h0F, 8'hF0, 1'b0, 1'b0}, '{8'hF0, 8'h0F, 1'b0, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("ncc_stereo_disparity_search: mismatch");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int window_ncc(int x, int y, int xr);
    longint s1, s2, s11, s22, s12, a, b, c, s;
    longint unsigned v1, v2, d, mag, q;
    s1 = 0; s2 = 0; s11 = 0; s22 = 0; s12 = 0;
    for (int j = -RAD; j <= RAD; j++) begin
      for (int i = -RAD; i <= RAD; i++) begin
        a = left_ring[((y + j) % RING) * MAXW + x + i];
        b = right_ring[((y + j) % RING) * MAXW + xr + i];
        s1 += a; s2 += b; s11 += a * a; s22 += b * b; s12 += a * b;
      end
    end
    c = NWIN * s12 - s1 * s2;
    v1 = NWIN * s11 - s1 * s1;
    v2 = NWIN * s22 - s2 * s2;
    d = 10 * int_sqrt(v1 * v2) + NWIN;
    mag = longint'(c < 0 ? -c : c) * 327680;
    q = (2 * mag + d) / (2 * d);
    s = c < 0 ? -longint'(q) : longint'(q);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return int'(s);
  endfunction

  function automatic int eff_width();
    int w;
    w = (width_reg < 1) ? 1 : int'(width_reg);
    return (w > MAXW) ? MAXW : w;
  endfunction

  function automatic int eff_height();
    int h;
    h = (height_reg < 1) ? 1 : int'(height_reg);
    return (h > 1024) ? 1024 : h;
  endfunction

  // advance the mirrored stream and work out the match for the trailing pixel
  function automatic bit match_pixel(ncc_in_t px, output ncc_out_t res);
    int w, h, cx, cy, dlo, dhi, lag, q, x, y, best_d, best, sc;
    bit seed;
    w = eff_width();
    h = eff_height();
    res = '0;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    cx = col_pos;
    cy = row_pos;
    left_ring[(cy % RING) * MAXW + cx] = px.left_pixel;
    right_ring[(cy % RING) * MAXW + cx] = px.right_pixel;
    if (cx + 1 >= w) begin
      col_pos = 0;
      row_pos = (cy + 1 >= h) ? 0 : cy + 1;
    end else begin
      col_pos = cx + 1;
    end
    dlo = dmin_reg;
    dhi = dmax_reg;
    if (dhi > dlo + SPAN - 1) dhi = dlo + SPAN - 1;
    lag = RAD + (dhi > 0 ? dhi : 0);
    q = cy * w + cx - RAD * w - lag;
    if (q < 0) return 1'b0;
    x = q % w;
    y = q / w;
    if (x < RAD || x + RAD > w - 1 || y < RAD || y + RAD > h - 1) return 1'b0;
    best_d = dlo - 1;
    best = -32768;
    seed = 1'b0;
    for (int d = dlo; d <= dhi; d++) begin
      if (x + d + RAD < w && x + d - RAD >= 0) begin
        sc = window_ncc(x, y, x + d);
        if (sc >= thresh_reg && sc >= best) begin
          best = sc;
          best_d = d;
          seed = 1'b1;
        end
      end
    end
    res.pixel_x = 10'(x);
    res.pixel_y = 10'(y);
    res.disparity = 8'(best_d);
    res.is_seed = seed;
    res.best_score = 16'(best);
    return 1'b1;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   width_reg = val[10:0];
      REG_IMAGE_HEIGHT:  height_reg = val[10:0];
      REG_NCC_THRESHOLD: thresh_reg = val;
      REG_DISPARITY_MIN: dmin_reg = val[6:0];
      REG_DISPARITY_MAX: dmax_reg = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_search(int w, int h, int thr, int dlo, int dhi);
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
    write_reg(REG_NCC_THRESHOLD, 16'(thr));
    write_reg(REG_DISPARITY_MIN, 16'(dlo));
    write_reg(REG_DISPARITY_MAX, 16'(dhi));
  endtask

  // returns whether the pixel produced a match, as predicted
  task automatic send_pixel(ncc_in_t px, output bit produced);
    ncc_out_t res;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    pixels_sent++;
    produced = match_pixel(px, res);
    if (produced) pending_matches.push_back(res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [7:0] clip8(int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // send up to limit pixels of one frame: mostly shifted texture pairs
  task automatic send_frame(int limit);
    logic [7:0] row_l[MAXW];
    int w, h, n, pattern, shift, base, src;
    bit produced;
    ncc_in_t px;
    w = eff_width();
    h = eff_height();
    n = 0;
    for (int y = 0; y < h && n < limit; y++) begin
      pattern = $urandom_range(0, 9);
      shift = $urandom_range(0, 8) - 4;
      base = $urandom_range(0, 255);
      for (int x = 0; x < w; x++) begin
        case (pattern)
          7: row_l[x] = 8'(base);
          8: row_l[x] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: row_l[x] = 8'($urandom_range(0, 255));
        endcase
      end
      for (int x = 0; x < w && n < limit; x++) begin
        src = x - shift;
        if (src < 0 || src >= w) src = x;
        px.left_pixel = row_l[x];
        case (pattern)
          5: px.right_pixel = clip8(int'(row_l[src]) + $urandom_range(0, 40) - 20);
          6: px.right_pixel = ~row_l[src];
          7: px.right_pixel = 8'(base ^ 8'h5A);
          9: px.right_pixel = 8'($urandom_range(0, 255));
          default: px.right_pixel = row_l[src];
        endcase
        px.frame_start = (n == 0);
        send_pixel(px, produced);
        n++;
      end
    end
  endtask

  task automatic idle_mode(int m);
    case (m % 3)
      0: begin tx_idle_pct = 11; rx_idle_pct = 78; end
      1: begin tx_idle_pct = 78; rx_idle_pct = 11; end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(negedge clk_i) begin
    ncc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      matches_seen++;
      if (out_data_o.is_seed) seeds_seen++;
      else fallbacks_seen++;
      if (pending_matches.size() == 0) begin
        $error("unexpected match transaction x=%0d y=%0d",
               out_data_o.pixel_x, out_data_o.pixel_y);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        if (out_data_o.pixel_x !== want.pixel_x) begin
          $error("pixel_x expected %0d got %0d", want.pixel_x, out_data_o.pixel_x);
          mismatches++;
        end
        if (out_data_o.pixel_y !== want.pixel_y) begin
          $error("pixel_y expected %0d got %0d", want.pixel_y, out_data_o.pixel_y);
          mismatches++;
        end
        if (out_data_o.disparity !== want.disparity) begin
          $error("disparity expected %0d got %0d", want.disparity, out_data_o.disparity);
          mismatches++;
        end
        if (out_data_o.is_seed !== want.is_seed) begin
          $error("is_seed expected %0d got %0d", want.is_seed, out_data_o.is_seed);
          mismatches++;
        end
        if (out_data_o.best_score !== want.best_score) begin
          $error("best_score expected %0d got %0d", want.best_score,
                 out_data_o.best_score);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit produced;
    ncc_in_t px;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    mismatches = 0;
    pixels_sent = 0;
    matches_seen = 0;
    seeds_seen = 0;
    fallbacks_seen = 0;
    col_pos = 0;
    row_pos = 0;
    width_reg = IMAGE_WIDTH_RST;
    height_reg = IMAGE_HEIGHT_RST;
    thresh_reg = THRESHOLD_RST;
    dmin_reg = DISP_MIN_RST;
    dmax_reg = DISP_MAX_RST;
    idle_mode(0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero sizes saturate to a single pixel
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    foreach (directed_rows[i]) begin
      px.left_pixel = directed_rows[i].left;
      px.right_pixel = directed_rows[i].right;
      px.frame_start = directed_rows[i].fs;
      send_pixel(px, produced);
      if (produced !== directed_rows[i].has_match) begin
        $error("directed row %0d: match expected %0d got %0d", i,
               directed_rows[i].has_match, produced);
        mismatches++;
      end
    end
    drain();

    // dense search, narrow range
    idle_mode(0);
    set_search(16, 16, -32768, -3, 3);
    send_frame(256);
    send_frame(256);
    drain();

    // seed threshold, wider image, asymmetric range
    idle_mode(1);
    set_search(20, 16, 16384, -4, 6);
    send_frame(320);
    drain();

    // extreme range: span capped, every window leaves the row
    idle_mode(2);
    set_search(16, 16, 32767, -64, 63);
    send_frame(256);
    drain();

    // empty range, then a frame cut short by a new frame start
    idle_mode(0);
    set_search(16, 16, 0, 5, -5);
    send_frame(100);
    send_frame(256);
    drain();

    // oversized registers saturate; partial frame only
    idle_mode(1);
    set_search(2047, 2047, -1, 0, 0);
    send_frame(150);
    drain();

    $display("covered %0d pixels over six search settings: %0d matches, %0d seeds, %0d fallbacks",
             pixels_sent, matches_seen, seeds_seen, fallbacks_seen);
    $display("sizes, thresholds and disparity ranges included their saturating extremes");
    if (mismatches == 0) $display("ncc_stereo_disparity_search: match");
    else $display("ncc_stereo_disparity_search: mismatch");
    $finish;
  end

endmodule
